FILE: src/scd_pkg.sv
// Package for the serial clock divisor search: widths, codes, types and defaults.
`default_nettype none

package scd_pkg;

  // Field widths
  localparam int PORT_W  = 3;
  localparam int SPEED_W = 27;
  localparam int BITS_W  = 5;
  localparam int MODE_W  = 2;
  localparam int CLK_W   = 28;
  localparam int OFF_W   = 5;
  localparam int VAL_W   = 16;

  // Search widths: scale lives in control0[15:8], half is at most 127
  localparam int SCALE_W = 8;
  localparam int HALF_W  = 7;

  // Divider widths: dividend is clk + 2*speed - 1, divisor is 2*speed
  localparam int DVD_W = 29;
  localparam int DVS_W = 28;

  // Defaults
  localparam int MAX_SCALE_DEF    = 255;
  localparam int MAX_PRESCALE_DEF = 254;
  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(66000000);
  localparam logic [PORT_W-1:0] PORT_MAX = PORT_W'(4);

  // Register offsets and fixed values
  localparam logic [OFF_W-1:0] OFF_CTRL0    = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_CTRL1    = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_PRESCALE = OFF_W'(16);
  localparam logic [VAL_W-1:0] CTRL1_VALUE  = VAL_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HD_GO,
    ST_HD_WAIT,
    ST_TRY_GO,
    ST_TRY_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    WR_CTRL0,
    WR_CTRL1,
    WR_PRESC
  } wr_sel_t;

  // Divider request and result
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dvd;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

FILE: src/scd_ifs.sv
// Valid/ready channel interfaces for the request and register-write items.
`default_nettype none

interface scd_in_if;
  logic                         valid;
  logic                         ready;
  logic [scd_pkg::PORT_W-1:0]   port_number;
  logic [scd_pkg::SPEED_W-1:0]  target_speed_hz;
  logic [scd_pkg::BITS_W-1:0]   word_bits;
  logic [scd_pkg::MODE_W-1:0]   mode_bits;

  modport source (output valid, port_number, target_speed_hz, word_bits, mode_bits,
                  input ready);
  modport sink   (input valid, port_number, target_speed_hz, word_bits, mode_bits,
                  output ready);
endinterface

interface scd_out_if;
  logic                        valid;
  logic                        ready;
  logic [scd_pkg::PORT_W-1:0]  port_select;
  logic [scd_pkg::OFF_W-1:0]   reg_offset;
  logic [scd_pkg::VAL_W-1:0]   reg_value;
  logic                        last_write;

  modport source (output valid, port_select, reg_offset, reg_value, last_write,
                  input ready);
  modport sink   (input valid, port_select, reg_offset, reg_value, last_write,
                  output ready);
endinterface

`default_nettype wire

FILE: src/spi_clock_divisor_search.sv
// Top level: serial clock divisor search and three-write register sequencer.
//
// Each request item yields three register-write items (control0, control1,
// prescale) for the chosen port. The block works on one request at a time:
// in_ch.ready is high only while idle. All divisions go through one shared
// bit-serial divider. A request tries 1 to MAX_SCALE + 1 scale values,
// fewer when an exact divisor is found early; a zero half divisor skips
// the scale search entirely.
// input_clock_hz resets to 66 MHz and is written through cfg_wr_en/cfg_wr_data.
`default_nettype none

module spi_clock_divisor_search #(
  parameter int MAX_SCALE    = scd_pkg::MAX_SCALE_DEF,
  parameter int MAX_PRESCALE = scd_pkg::MAX_PRESCALE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  scd_in_if.sink                         in_ch,
  scd_out_if.source                      out_ch,
  input  wire logic                      cfg_wr_en,
  input  wire logic [scd_pkg::CLK_W-1:0] cfg_wr_data
);

  localparam int CLK_W   = scd_pkg::CLK_W;
  localparam int SPEED_W = scd_pkg::SPEED_W;
  localparam int SCALE_W = scd_pkg::SCALE_W;
  localparam int HALF_W  = scd_pkg::HALF_W;
  localparam int DVD_W   = scd_pkg::DVD_W;
  localparam int DVS_W   = scd_pkg::DVS_W;
  localparam int HALF_MAX = MAX_PRESCALE / 2;
  localparam logic [SCALE_W-1:0] SCALE_LAST = SCALE_W'(MAX_SCALE);
  localparam logic [HALF_W-1:0]  HALF_LAST  = HALF_W'(HALF_MAX);

  scd_pkg::state_t  state_r, state_nxt;
  scd_pkg::wr_sel_t wr_sel_r, wr_sel_nxt;

  logic [CLK_W-1:0]   clk_hz_r;
  logic [SPEED_W-1:0] speed_r;
  logic [scd_pkg::PORT_W-1:0] port_r;
  logic [scd_pkg::BITS_W-1:0] size_r;
  logic [scd_pkg::MODE_W-1:0] mode_r;

  logic [CLK_W-1:0]   hd_r;
  logic [CLK_W-1:0]   low_err_r;
  logic [SCALE_W-1:0] best_scale_r;
  logic [HALF_W-1:0]  best_half_r;
  logic [SCALE_W-1:0] scale_r;

  scd_pkg::div_req_t div_req;
  scd_pkg::div_res_t div_res;

  logic               in_fire, out_fire;
  logic               half_ok, better;
  logic [SCALE_W-1:0] try_err;
  logic [CLK_W-1:0]   hd_new;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  scd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Clock frequency register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= scd_pkg::CLK_RESET;
    end else if (cfg_wr_en) begin
      clk_hz_r <= cfg_wr_data;
    end
  end

  // Trial evaluation: half = ceil(hd / (scale+1)), err = scale - remainder
  assign hd_new  = div_res.quot[CLK_W-1:0];
  assign half_ok = div_res.quot <= DVD_W'(HALF_MAX);
  assign try_err = scale_r - div_res.rem[SCALE_W-1:0];
  assign better  = half_ok && ({{(CLK_W-SCALE_W){1'b0}}, try_err} < low_err_r);

  // Next state
  always_comb begin
    state_nxt  = state_r;
    wr_sel_nxt = wr_sel_r;
    unique case (state_r)
      scd_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = scd_pkg::ST_HD_GO;
      end
      scd_pkg::ST_HD_GO: begin
        state_nxt = scd_pkg::ST_HD_WAIT;
      end
      scd_pkg::ST_HD_WAIT: begin
        if (div_res.done) begin
          state_nxt = (hd_new == '0) ? scd_pkg::ST_EMIT : scd_pkg::ST_TRY_GO;
        end
      end
      scd_pkg::ST_TRY_GO: begin
        state_nxt = scd_pkg::ST_TRY_WAIT;
      end
      scd_pkg::ST_TRY_WAIT: begin
        if (div_res.done) begin
          if ((better && try_err == '0) || scale_r == SCALE_LAST) begin
            state_nxt = scd_pkg::ST_EMIT;
          end else begin
            state_nxt = scd_pkg::ST_TRY_GO;
          end
        end
      end
      scd_pkg::ST_EMIT: begin
        if (out_fire) begin
          unique case (wr_sel_r)
            scd_pkg::WR_CTRL0: wr_sel_nxt = scd_pkg::WR_CTRL1;
            scd_pkg::WR_CTRL1: wr_sel_nxt = scd_pkg::WR_PRESC;
            default: begin
              wr_sel_nxt = scd_pkg::WR_CTRL0;
              state_nxt  = scd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = scd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and divider requests
  always_comb begin
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;
    div_req.start = 1'b0;
    div_req.dvd   = DVD_W'(hd_r) + DVD_W'(scale_r);
    div_req.dvs   = DVS_W'(scale_r) + DVS_W'(1);
    unique case (state_r)
      scd_pkg::ST_IDLE: in_ch.ready = 1'b1;
      scd_pkg::ST_HD_GO: begin
        div_req.start = 1'b1;
        div_req.dvd   = DVD_W'(clk_hz_r) + DVD_W'({speed_r, 1'b0}) - DVD_W'(1);
        div_req.dvs   = DVS_W'({speed_r, 1'b0});
      end
      scd_pkg::ST_TRY_GO: div_req.start = 1'b1;
      scd_pkg::ST_EMIT:   out_ch.valid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= scd_pkg::ST_IDLE;
      wr_sel_r <= scd_pkg::WR_CTRL0;
    end else begin
      state_r  <= state_nxt;
      wr_sel_r <= wr_sel_nxt;
    end
  end

  // Request capture and search bookkeeping
  always_ff @(posedge clk) begin
    if (in_fire) begin
      speed_r <= (in_ch.target_speed_hz == '0) ? SPEED_W'(1) : in_ch.target_speed_hz;
      port_r  <= (in_ch.port_number > scd_pkg::PORT_MAX) ? scd_pkg::PORT_MAX
                                                          : in_ch.port_number;
      size_r  <= in_ch.word_bits - scd_pkg::BITS_W'(1);
      mode_r  <= in_ch.mode_bits;
    end
    if (state_r == scd_pkg::ST_HD_WAIT && div_res.done) begin
      hd_r         <= hd_new;
      low_err_r    <= hd_new;
      best_scale_r <= SCALE_LAST;
      best_half_r  <= HALF_LAST;
      scale_r      <= '0;
    end
    if (state_r == scd_pkg::ST_TRY_WAIT && div_res.done) begin
      if (better) begin
        low_err_r    <= {{(CLK_W-SCALE_W){1'b0}}, try_err};
        best_scale_r <= scale_r;
        best_half_r  <= div_res.quot[HALF_W-1:0];
      end
      scale_r <= scale_r + SCALE_W'(1);
    end
  end

  // Write items
  always_comb begin
    out_ch.port_select = port_r;
    out_ch.last_write  = 1'b0;
    case (wr_sel_r)
      scd_pkg::WR_CTRL0: begin
        out_ch.reg_offset = scd_pkg::OFF_CTRL0;
        out_ch.reg_value  = {best_scale_r, mode_r[0], mode_r[1], 1'b0, size_r};
      end
      scd_pkg::WR_CTRL1: begin
        out_ch.reg_offset = scd_pkg::OFF_CTRL1;
        out_ch.reg_value  = scd_pkg::CTRL1_VALUE;
      end
      default: begin
        out_ch.reg_offset = scd_pkg::OFF_PRESCALE;
        out_ch.reg_value  = scd_pkg::VAL_W'({best_half_r, 1'b0});
        out_ch.last_write = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request accepted while a search is running");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_write |=> state_r == scd_pkg::ST_IDLE)
    else $error("sequencer did not return to idle after the last write");

  a_half_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == scd_pkg::ST_EMIT |-> best_half_r != '0 && best_half_r <= HALF_LAST)
    else $error("chosen prescale half out of range");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == scd_pkg::ST_HD_WAIT || state_r == scd_pkg::ST_TRY_WAIT)
    else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

FILE: src/scd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`default_nettype none

module scd_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scd_pkg::div_req_t req,
  output scd_pkg::div_res_t      res
);

  localparam int DVD_W = scd_pkg::DVD_W;
  localparam int DVS_W = scd_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quot_r, quot_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   trial;
  logic [DVS_W+1:0] diff;
  logic             fit;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem_r, quot_r[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign fit   = !diff[DVS_W+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = req.dvd;
      rem_nxt  = '0;
      dvs_nxt  = req.dvs;
    end else if (busy_r) begin
      quot_nxt = {quot_r[DVD_W-2:0], fit};
      rem_nxt  = fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire
